// ----- hdl/bfa_pkg.sv -----
package bfa_pkg;

  // internal width of offsets and sizes; the bump pointer keeps growing past
  // 32 bits once the limit is lowered below the current heap top
  localparam int VAL_W = 64;

  localparam logic [6:0] HDR_RESET = 7'd24;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ASCAN,
    S_ADONE,
    S_USCAN,
    S_FSCAN,
    S_FDONE
  } state_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_LIMIT   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic {
    CFG_HEADER = 1'b0,
    CFG_LIMIT  = 1'b1
  } cfg_idx_t;

endpackage

// ----- hdl/bfa_ram.sv -----
module bfa_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/best_fit_heap_allocator.sv -----
// Channel | Ports                                              | Handshake
// request | in_kind, in_request_bytes, in_payload_offset       | start & !busy
// result  | out_status, out_granted_offset, out_heap_bytes,    | out_valid strobe
//         | out_free_bytes                                     |
// config  | cfg_index, cfg_data                                | cfg_valid & cfg_ready
//
// Allocate: one free-table entry read per cycle from the free-table RAM.
// Free: a pass over the used-table RAM then, if the block is found, one over
// the free-table RAM. A null free answers in the next cycle.
// Synchronous active-low reset; tables need no clearing pass.
// The result strobe cannot be stalled; cfg_ready is low while busy or start.
module best_fit_heap_allocator #(
  parameter int FREE_SLOTS = 64,
  parameter int USED_SLOTS = 64,
  parameter int ADDR_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [31:0] in_request_bytes,
  input  logic [31:0] in_payload_offset,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_granted_offset,
  output logic [31:0] out_heap_bytes,
  output logic [31:0] out_free_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int VW     = bfa_pkg::VAL_W;
  localparam int FIW    = $clog2(FREE_SLOTS);
  localparam int UIW    = $clog2(USED_SLOTS);
  localparam int NMAX   = (FREE_SLOTS > USED_SLOTS) ? FREE_SLOTS : USED_SLOTS;
  localparam int CW     = $clog2(NMAX + 1);
  localparam int CAPB   = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam logic [VW-1:0] AMAX = (VW'(1) << CAPB) - VW'(1);

  bfa_pkg::state_t state_r, state_nxt;

  // configuration
  logic [6:0]  header_r;
  logic [31:0] limit_r;

  // request
  logic        kind_r;
  logic [31:0] size_r;
  logic [31:0] off_r;

  // tables and totals
  logic [FREE_SLOTS-1:0] fvalid_r;
  logic [USED_SLOTS-1:0] uvalid_r;
  logic [VW-1:0]         heap_top_r;
  logic [31:0]           free_total_r;

  // scan pipeline
  logic [CW-1:0] cnt_r, idx_r;
  logic          pv_r, issue, scan_end;
  logic [CW-1:0] lim;

  // search results
  logic          found_r, exact_r, ufound_r, nfound_r, pfound_r, sfound_r;
  logic [FIW-1:0] best_r, nidx_r, pidx_r, sidx_r;
  logic [UIW-1:0] uidx_r;
  logic [VW-1:0] bst_r, blen_r, bdiff_r, ust_r, ulen_r, end_r, nlen_r, pst_r, plen_r;

  // RAM ports
  logic                fw_en, uw_en;
  logic [FIW-1:0]      fw_addr;
  logic [UIW-1:0]      uw_addr;
  logic [2*VW-1:0]     fw_data, uw_data, fr_data, ur_data;

  // commit controls
  logic          res_fire;
  logic [1:0]    res_status;
  logic [31:0]   res_grant;
  logic [VW-1:0] ht_nxt;
  logic [31:0]   ft_nxt;
  logic          fv_clr, fv_set, uv_clr, uv_set;
  logic [FIW-1:0] fv_clr_idx, fv_set_idx;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [31:0]   out_grant_r, out_heap_r, out_free_r;

  logic [VW-1:0] h, size_x, cap, f_st, f_ln, u_st, u_ln, d, ln_m;
  logic          accept, cap_fail;

  assign h      = (header_r == 7'd0) ? VW'(1) : VW'(header_r);
  assign size_x = VW'(size_r);
  assign cap    = (VW'(limit_r) < AMAX) ? VW'(limit_r) : AMAX;
  assign f_st   = fr_data[2*VW-1:VW];
  assign f_ln   = fr_data[VW-1:0];
  assign u_st   = ur_data[2*VW-1:VW];
  assign u_ln   = ur_data[VW-1:0];
  assign d      = f_ln - size_x;
  assign accept = start && (state_r == bfa_pkg::S_IDLE);
  assign busy   = (state_r != bfa_pkg::S_IDLE);
  // settings change only with nothing in flight
  assign cfg_ready = !busy && !start;

  bfa_ram #(.WIDTH(2*VW), .DEPTH(FREE_SLOTS)) u_free_ram (
    .clk(clk), .we(fw_en), .waddr(fw_addr), .wdata(fw_data),
    .raddr(cnt_r[FIW-1:0]), .rdata(fr_data)
  );

  bfa_ram #(.WIDTH(2*VW), .DEPTH(USED_SLOTS)) u_used_ram (
    .clk(clk), .we(uw_en), .waddr(uw_addr), .wdata(uw_data),
    .raddr(cnt_r[UIW-1:0]), .rdata(ur_data)
  );

  // scan limits
  always_comb begin
    unique case (state_r)
      bfa_pkg::S_ASCAN: lim = CW'(NMAX);
      bfa_pkg::S_USCAN: lim = CW'(USED_SLOTS);
      bfa_pkg::S_FSCAN: lim = CW'(FREE_SLOTS);
      default:          lim = '0;
    endcase
    issue    = (cnt_r < lim);
    scan_end = !issue && !pv_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfa_pkg::S_IDLE: begin
        if (accept) begin
          if (in_kind == bfa_pkg::KIND_ALLOC) state_nxt = bfa_pkg::S_ASCAN;
          else if (in_payload_offset != 32'd0) state_nxt = bfa_pkg::S_USCAN;
        end
      end
      bfa_pkg::S_ASCAN: if (scan_end) state_nxt = bfa_pkg::S_ADONE;
      bfa_pkg::S_USCAN: begin
        if (scan_end) state_nxt = ufound_r ? bfa_pkg::S_FSCAN : bfa_pkg::S_FDONE;
      end
      bfa_pkg::S_FSCAN: if (scan_end) state_nxt = bfa_pkg::S_FDONE;
      bfa_pkg::S_ADONE: state_nxt = bfa_pkg::S_IDLE;
      bfa_pkg::S_FDONE: state_nxt = bfa_pkg::S_IDLE;
      default:          state_nxt = bfa_pkg::S_IDLE;
    endcase
  end

  // commit decisions
  always_comb begin
    res_fire   = 1'b0;
    res_status = bfa_pkg::STAT_OK;
    res_grant  = 32'd0;
    ht_nxt     = heap_top_r;
    ft_nxt     = free_total_r;
    fw_en      = 1'b0;
    fw_addr    = best_r;
    fw_data    = '0;
    uw_en      = 1'b0;
    uw_addr    = uidx_r;
    uw_data    = '0;
    fv_clr     = 1'b0;
    fv_set     = 1'b0;
    uv_clr     = 1'b0;
    uv_set     = 1'b0;
    fv_clr_idx = best_r;
    fv_set_idx = sidx_r;
    cap_fail   = (heap_top_r <= cap) && ((size_x + h) > (cap - heap_top_r));
    ln_m       = nfound_r ? (ulen_r + h + nlen_r) : ulen_r;
    unique case (state_r)
      bfa_pkg::S_IDLE: begin
        // null free answers at once
        if (accept && in_kind == bfa_pkg::KIND_FREE && in_payload_offset == 32'd0) begin
          res_fire = 1'b1;
        end
      end
      bfa_pkg::S_ADONE: begin
        res_fire = 1'b1;
        if (!ufound_r) begin
          res_status = bfa_pkg::STAT_FULL;
        end else if (found_r) begin
          uw_en     = 1'b1;
          uv_set    = 1'b1;
          res_grant = 32'(bst_r + h);
          if (blen_r > size_x + h) begin
            fw_en   = 1'b1;
            fw_data = {bst_r + h + size_x, blen_r - size_x - h};
            ft_nxt  = free_total_r - size_r - 32'(h);
            uw_data = {bst_r, size_x};
          end else begin
            fv_clr  = 1'b1;
            ft_nxt  = free_total_r - 32'(blen_r) - 32'(h);
            uw_data = {bst_r, blen_r};
          end
        end else if (cap_fail) begin
          res_status = bfa_pkg::STAT_LIMIT;
        end else begin
          uw_en     = 1'b1;
          uv_set    = 1'b1;
          uw_data   = {heap_top_r, size_x};
          res_grant = 32'(heap_top_r + h);
          ht_nxt    = heap_top_r + size_x + h;
        end
      end
      bfa_pkg::S_FDONE: begin
        res_fire = 1'b1;
        if (!ufound_r) begin
          res_status = bfa_pkg::STAT_UNKNOWN;
        end else if (!pfound_r && !nfound_r && !sfound_r) begin
          res_status = bfa_pkg::STAT_FULL;
        end else begin
          uv_clr     = 1'b1;
          ft_nxt     = free_total_r + 32'(ulen_r) + 32'(h);
          fw_en      = 1'b1;
          if (pfound_r) begin
            // next neighbor folds into the previous one
            fv_clr     = nfound_r;
            fv_clr_idx = nidx_r;
            fw_addr    = pidx_r;
            fw_data    = {pst_r, plen_r + h + ln_m};
          end else begin
            fw_addr    = nfound_r ? nidx_r : sidx_r;
            fw_data    = {ust_r, ln_m};
            fv_set     = 1'b1;
            fv_set_idx = fw_addr;
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bfa_pkg::S_IDLE;
      header_r     <= bfa_pkg::HDR_RESET;
      limit_r      <= '1;
      fvalid_r     <= '0;
      uvalid_r     <= '0;
      heap_top_r   <= '0;
      free_total_r <= '0;
      cnt_r        <= '0;
      pv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bfa_pkg::CFG_HEADER) header_r <= cfg_data[6:0];
        else limit_r <= cfg_data;
      end
      heap_top_r   <= ht_nxt;
      free_total_r <= ft_nxt;
      if (fv_clr) fvalid_r[fv_clr_idx] <= 1'b0;
      if (fv_set) fvalid_r[fv_set_idx] <= 1'b1;
      if (uv_clr) uvalid_r[uidx_r] <= 1'b0;
      if (uv_set) uvalid_r[uidx_r] <= 1'b1;
      // scan counter restarts between passes
      if (state_r == bfa_pkg::S_IDLE || (state_r == bfa_pkg::S_USCAN && scan_end)) begin
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + CW'(1);
      end
      pv_r        <= issue;
      out_valid_r <= res_fire;
    end
  end

  // request, search and result payload
  always_ff @(posedge clk) begin
    idx_r <= cnt_r;
    if (res_fire) begin
      out_status_r <= res_status;
      out_grant_r  <= res_grant;
      out_heap_r   <= ht_nxt[31:0];
      out_free_r   <= ft_nxt;
    end
    if (accept) begin
      kind_r   <= in_kind;
      size_r   <= in_request_bytes;
      off_r    <= in_payload_offset;
      found_r  <= 1'b0;
      exact_r  <= 1'b0;
      ufound_r <= 1'b0;
      nfound_r <= 1'b0;
      pfound_r <= 1'b0;
      sfound_r <= 1'b0;
    end
    if (state_r == bfa_pkg::S_USCAN && scan_end) begin
      end_r <= ust_r + h + ulen_r;
    end
    if (pv_r) begin
      unique case (state_r)
        bfa_pkg::S_ASCAN: begin
          // best fit over the free table
          if (idx_r < CW'(FREE_SLOTS) && fvalid_r[idx_r[FIW-1:0]]) begin
            if (f_ln == size_x) begin
              if (!exact_r || f_st < bst_r) begin
                best_r <= idx_r[FIW-1:0];
                bst_r  <= f_st;
                blen_r <= f_ln;
              end
              exact_r <= 1'b1;
              found_r <= 1'b1;
            end else if (!exact_r && f_ln > size_x) begin
              if (!found_r || d < bdiff_r || (d == bdiff_r && f_st < bst_r)) begin
                best_r  <= idx_r[FIW-1:0];
                bst_r   <= f_st;
                blen_r  <= f_ln;
                bdiff_r <= d;
              end
              found_r <= 1'b1;
            end
          end
          // first empty used slot
          if (idx_r < CW'(USED_SLOTS) && !uvalid_r[idx_r[UIW-1:0]] && !ufound_r) begin
            ufound_r <= 1'b1;
            uidx_r   <= idx_r[UIW-1:0];
          end
        end
        bfa_pkg::S_USCAN: begin
          // find the allocated block owning the offset
          if (!ufound_r && uvalid_r[idx_r[UIW-1:0]] && (u_st + h == VW'(off_r))) begin
            ufound_r <= 1'b1;
            uidx_r   <= idx_r[UIW-1:0];
            ust_r    <= u_st;
            ulen_r   <= u_ln;
          end
        end
        bfa_pkg::S_FSCAN: begin
          // neighbors and a spare slot
          if (!fvalid_r[idx_r[FIW-1:0]]) begin
            if (!sfound_r) begin
              sfound_r <= 1'b1;
              sidx_r   <= idx_r[FIW-1:0];
            end
          end else if (!nfound_r && f_st == end_r) begin
            nfound_r <= 1'b1;
            nidx_r   <= idx_r[FIW-1:0];
            nlen_r   <= f_ln;
          end else if (!pfound_r && (f_st + h + f_ln == ust_r)) begin
            pfound_r <= 1'b1;
            pidx_r   <= idx_r[FIW-1:0];
            pst_r    <= f_st;
            plen_r   <= f_ln;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_offset = out_grant_r;
  assign out_heap_bytes     = out_heap_r;
  assign out_free_bytes     = out_free_r;

  // an accepted request either starts a search or answers next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy || out_valid)
    else $error("accepted request neither busy nor answered");

  // failed requests grant nothing
  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != bfa_pkg::STAT_OK |-> out_granted_offset == 32'd0)
    else $error("grant on failed request");

  // failed requests leave the heap top alone
  a_fail_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != bfa_pkg::STAT_OK |-> $stable(heap_top_r))
    else $error("heap top moved on failure");

  // a free request never moves the bump pointer
  a_free_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind_r == bfa_pkg::KIND_FREE |-> $stable(heap_top_r))
    else $error("heap top moved on free");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int SLOTS = 64;
  localparam int MAX_CYCLES = 1000000;

  typedef struct {
    bfa_pkg::status_t status;
    logic [31:0]      granted;
    logic [31:0]      heap;
    logic [31:0]      free_sum;
  } alloc_result_t;

  // Tracks the allocator tables and queues the answer of each accepted request
  class heap_scoreboard;
    logic [63:0]   fr_start [SLOTS];
    logic [63:0]   fr_len [SLOTS];
    bit            fr_valid [SLOTS];
    logic [63:0]   us_start [SLOTS];
    logic [63:0]   us_len [SLOTS];
    bit            us_valid [SLOTS];
    logic [63:0]   top;
    logic [31:0]   free_sum;
    logic [6:0]    hdr_cfg;
    logic [31:0]   limit_cfg;
    alloc_result_t pending [$];
    int            errors;

    function void clear();
      for (int i = 0; i < SLOTS; i++) begin
        fr_valid[i] = 0;
        us_valid[i] = 0;
      end
      top = 0;
      free_sum = 0;
      hdr_cfg = bfa_pkg::HDR_RESET;
      limit_cfg = 32'hFFFF_FFFF;
      errors = 0;
    endfunction

    function logic [63:0] hdr();
      return (hdr_cfg == 0) ? 64'd1 : {57'd0, hdr_cfg};
    endfunction

    function void set_reg(bfa_pkg::cfg_idx_t idx, logic [31:0] data);
      if (idx == bfa_pkg::CFG_HEADER) hdr_cfg = data[6:0];
      else limit_cfg = data;
    endfunction

    function bfa_pkg::status_t allocate(logic [63:0] size, output logic [63:0] granted);
      logic [63:0] h, bdiff, d, st, blen, cap;
      int u, best;
      bit exact;
      h = hdr();
      u = -1;
      best = -1;
      exact = 0;
      bdiff = 0;
      granted = 0;
      for (int i = SLOTS - 1; i >= 0; i--)
        if (!us_valid[i]) u = i;
      if (u < 0) return bfa_pkg::STAT_FULL;
      for (int i = 0; i < SLOTS; i++) begin
        if (!fr_valid[i]) continue;
        if (fr_len[i] == size) begin
          if (!exact || fr_start[i] < fr_start[best]) best = i;
          exact = 1;
        end else if (!exact && fr_len[i] > size) begin
          d = fr_len[i] - size;
          if (best < 0 || d < bdiff || (d == bdiff && fr_start[i] < fr_start[best])) begin
            best = i;
            bdiff = d;
          end
        end
      end
      if (best >= 0) begin
        st = fr_start[best];
        blen = fr_len[best];
        if (blen > size + h) begin
          fr_start[best] = st + h + size;
          fr_len[best] = blen - size - h;
          free_sum = 32'(free_sum - size - h);
          blen = size;
        end else begin
          fr_valid[best] = 0;
          free_sum = 32'(free_sum - blen - h);
        end
        us_start[u] = st;
        us_len[u] = blen;
        us_valid[u] = 1;
        granted = st + h;
        return bfa_pkg::STAT_OK;
      end
      cap = {32'd0, limit_cfg};
      if (size + h > cap - top) return bfa_pkg::STAT_LIMIT;
      us_start[u] = top;
      us_len[u] = size;
      us_valid[u] = 1;
      granted = top + h;
      top = top + size + h;
      return bfa_pkg::STAT_OK;
    endfunction

    function bfa_pkg::status_t release_block(logic [63:0] off);
      logic [63:0] h, st, ln, blk_end;
      int u, prv, nxt, slot;
      h = hdr();
      u = -1;
      prv = -1;
      nxt = -1;
      slot = -1;
      if (off == 0) return bfa_pkg::STAT_OK;
      for (int i = 0; i < SLOTS; i++)
        if (u < 0 && us_valid[i] && us_start[i] + h == off) u = i;
      if (u < 0) return bfa_pkg::STAT_UNKNOWN;
      st = us_start[u];
      ln = us_len[u];
      blk_end = st + h + ln;
      for (int i = 0; i < SLOTS; i++) begin
        if (!fr_valid[i]) begin
          if (slot < 0) slot = i;
          continue;
        end
        if (nxt < 0 && fr_start[i] == blk_end) nxt = i;
        else if (prv < 0 && fr_start[i] + h + fr_len[i] == st) prv = i;
      end
      if (prv < 0 && nxt < 0 && slot < 0) return bfa_pkg::STAT_FULL;
      us_valid[u] = 0;
      free_sum = 32'(free_sum + ln + h);
      if (nxt >= 0) begin
        ln = ln + h + fr_len[nxt];
        fr_valid[nxt] = 0;
        slot = nxt;
      end
      if (prv >= 0) begin
        fr_len[prv] = fr_len[prv] + h + ln;
      end else begin
        fr_start[slot] = st;
        fr_len[slot] = ln;
        fr_valid[slot] = 1;
      end
      return bfa_pkg::STAT_OK;
    endfunction

    // Accepted request: predict its answer
    function void note_request(bfa_pkg::kind_t kind, logic [31:0] req, logic [31:0] off);
      alloc_result_t r;
      logic [63:0] g;
      g = 0;
      if (kind == bfa_pkg::KIND_ALLOC) r.status = allocate({32'd0, req}, g);
      else r.status = release_block({32'd0, off});
      r.granted = g[31:0];
      r.heap = top[31:0];
      r.free_sum = free_sum;
      pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check(logic [1:0] st, logic [31:0] g, logic [31:0] hb, logic [31:0] fb);
      alloc_result_t e;
      if (pending.size() == 0) begin
        report("unexpected result", {30'd0, st}, 32'd0);
        return;
      end
      e = pending.pop_front();
      if (st != e.status) report("status", {30'd0, st}, {30'd0, e.status});
      if (g != e.granted) report("granted_offset", g, e.granted);
      if (hb != e.heap) report("heap_bytes", hb, e.heap);
      if (fb != e.free_sum) report("free_bytes", fb, e.free_sum);
    endtask

    // A payload offset of some live block, or 0 when none is live
    function logic [31:0] pick_live();
      int n;
      int idx [$];
      n = 0;
      for (int i = 0; i < SLOTS; i++)
        if (us_valid[i]) idx.push_back(i);
      if (idx.size() == 0) return 32'd0;
      n = idx[$urandom_range(0, idx.size() - 1)];
      return 32'(us_start[n] + hdr());
    endfunction

    // Payload size of some free block, for exact-fit requests
    function logic [31:0] pick_free_len();
      int idx [$];
      for (int i = 0; i < SLOTS; i++)
        if (fr_valid[i]) idx.push_back(i);
      if (idx.size() == 0) return $urandom_range(0, 64);
      return 32'(fr_len[idx[$urandom_range(0, idx.size() - 1)]]);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_kind;
  logic [31:0] in_request_bytes;
  logic [31:0] in_payload_offset;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_granted_offset;
  logic [31:0] out_heap_bytes;
  logic [31:0] out_free_bytes;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  heap_scoreboard sb;
  int idle_pct;
  int cycles;

  best_fit_heap_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_request_bytes(in_request_bytes),
    .in_payload_offset(in_payload_offset), .out_valid(out_valid),
    .out_status(out_status), .out_granted_offset(out_granted_offset),
    .out_heap_bytes(out_heap_bytes), .out_free_bytes(out_free_bytes),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check(out_status, out_granted_offset, out_heap_bytes, out_free_bytes);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // One request: optional idle gap, then hold until accepted
  task send_request(bfa_pkg::kind_t kind, logic [31:0] req, logic [31:0] off);
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_kind = kind;
    in_request_bytes = req;
    in_payload_offset = off;
    do @(posedge clk); while (busy);
    sb.note_request(kind, req, off);
    @(negedge clk);
    start = 1'b0;
  endtask

  task alloc_req(logic [31:0] size);
    send_request(bfa_pkg::KIND_ALLOC, size, $urandom);
  endtask

  task free_req(logic [31:0] off);
    send_request(bfa_pkg::KIND_FREE, $urandom, off);
  endtask

  // Wait for every outstanding answer, then let the block settle
  task drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task write_reg(bfa_pkg::cfg_idx_t idx, logic [31:0] data);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task random_items(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) alloc_req($urandom_range(0, 256));
      else if (r < 38) alloc_req(sb.pick_free_len());
      else if (r < 42) alloc_req($urandom);
      else if (r < 48) alloc_req($urandom_range(0, 8192));
      else if (r < 85) free_req(sb.pick_live());
      else if (r < 91) free_req($urandom);
      else if (r < 95) free_req(32'd0);
      else free_req(sb.pick_live() + 1);
    end
  endtask

  initial begin
    logic [31:0] a, b, c;
    sb = new();
    sb.clear();
    cycles = 0;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = bfa_pkg::KIND_ALLOC;
    in_request_bytes = 0;
    in_payload_offset = 0;
    cfg_valid = 1'b0;
    cfg_index = bfa_pkg::CFG_HEADER;
    cfg_data = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: extremes, null and unknown frees, exact fit, split, merges
    alloc_req(32'd0);
    a = sb.pick_live();
    alloc_req(32'd100);
    alloc_req(32'hFFFF_FFFF);
    alloc_req(32'd40);
    alloc_req(32'd1);
    free_req(32'd0);
    free_req(32'hFFFF_FFFF);
    free_req(32'd5);
    free_req(a);
    free_req(a);
    alloc_req(32'd0);
    b = sb.pick_live();
    free_req(b);
    alloc_req(32'd300);
    c = sb.pick_live();
    free_req(c);
    alloc_req(32'd10);
    alloc_req(32'd300);
    alloc_req(32'd20);
    free_req(sb.pick_live());
    free_req(sb.pick_live());
    free_req(sb.pick_live());
    alloc_req(32'hFFFF_FF00);

    // Header of zero counts as one; upper data bits are dropped
    write_reg(bfa_pkg::CFG_HEADER, 32'd0);
    random_items(15);
    write_reg(bfa_pkg::CFG_HEADER, 32'hFFFF_FF7F);
    random_items(15);

    // A limit of zero, below the current heap top, then a small limit
    write_reg(bfa_pkg::CFG_LIMIT, 32'd0);
    random_items(20);
    write_reg(bfa_pkg::CFG_HEADER, 32'd1);
    write_reg(bfa_pkg::CFG_LIMIT, 32'h0004_0000);

    // Fill the used table past its depth
    for (int i = 0; i < 70; i++) alloc_req($urandom_range(0, 40));
    random_items(40);

    // Random phases over idle patterns and settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          write_reg(bfa_pkg::CFG_HEADER, 32'd64);
        end
        1: begin
          idle_pct = 63;
          write_reg(bfa_pkg::CFG_LIMIT, 32'hFFFF_FFFF);
        end
        2: begin
          idle_pct = 0;
          write_reg(bfa_pkg::CFG_HEADER, 32'd24);
        end
        default: begin
          idle_pct = 16;
          write_reg(bfa_pkg::CFG_HEADER, $urandom_range(1, 64));
          write_reg(bfa_pkg::CFG_LIMIT, 32'h0010_0000);
        end
      endcase
      random_items(120);
    end

    drain();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
